[rtl/pwdm_pkg.sv]
package pwdm_pkg;

  localparam int ANGLE_STEPS_DEF = 360;
  localparam int WINDOW_HALF_DEF = 2;
  localparam int DEG_FULL = 360;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF = 180;
  localparam int DEG_W = 9;
  localparam int POS_W = 13;
  localparam int DIST_W = 16;
  localparam int OUT_W = 13;
  localparam int CAP_Q4 = 6400;
  localparam int MAP_MAX = 65535;
  localparam int NUM_W = 28;
  localparam int DEN_W = 16;
  localparam int QUO_W = 29;
  localparam int SHIFT_Q14 = 14;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAY,
    ST_DIV,
    ST_WAIT,
    ST_STORE,
    ST_QDIV,
    ST_QADDR,
    ST_QCMP
  } state_e;

  localparam logic [14:0] SIN_ROM [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Angle is in 0..359.
  function automatic logic signed [DEN_W-1:0] sin_q14(input logic [DEG_W-1:0] deg);
    logic [14:0] mag;
    logic        neg;
    begin
      neg = 1'b0;
      if (deg <= DEG_W'(DEG_QUARTER)) begin
        mag = SIN_ROM[7'(deg)];
      end else if (deg <= DEG_W'(DEG_HALF)) begin
        mag = SIN_ROM[7'(DEG_W'(DEG_HALF) - deg)];
      end else if (deg <= DEG_W'(DEG_HALF + DEG_QUARTER)) begin
        mag = SIN_ROM[7'(deg - DEG_W'(DEG_HALF))];
        neg = 1'b1;
      end else begin
        mag = SIN_ROM[7'(DEG_W'(DEG_FULL) - deg)];
        neg = 1'b1;
      end
      sin_q14 = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endfunction

  function automatic logic signed [QUO_W-1:0] choose(input logic signed [QUO_W-1:0] a,
                                                     input logic signed [QUO_W-1:0] b);
    begin
      if (a < 0 || (b >= 0 && b < a)) choose = b;
      else choose = a;
    end
  endfunction

endpackage

[rtl/pwdm_ram.sv]
module pwdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 360
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/pwdm_div.sv]
module pwdm_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [pwdm_pkg::NUM_W-1:0]    num_i,
  input  logic signed [pwdm_pkg::DEN_W-1:0]    den_i,
  output logic                                 done_o,
  output logic signed [pwdm_pkg::QUO_W-1:0]    quo_o
);
  import pwdm_pkg::*;

  localparam int MW = NUM_W - 1;
  localparam int DM = DEN_W - 1;
  localparam int CW = $clog2(MW + 1);

  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MW-1:0] quo_q, quo_d;
  logic [DM-1:0] rem_q, rem_d;
  logic [DM-1:0] dmag_q, dmag_d;
  logic          neg_q, neg_d;
  logic          done_d;
  logic signed [QUO_W-1:0] res_d;
  logic signed [NUM_W-1:0] nabs;
  logic signed [DEN_W-1:0] dabs;
  logic [DM:0]   rsh;
  logic [DM+1:0] trial;

  assign nabs = num_i[NUM_W-1] ? -num_i : num_i;
  assign dabs = den_i[DEN_W-1] ? -den_i : den_i;
  assign rsh = {rem_q, quo_q[MW-1]};
  assign trial = {1'b0, rsh} - {2'b00, dmag_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dmag_d = dmag_q;
    neg_d = neg_q;
    done_d = 1'b0;
    res_d = quo_o;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = nabs[MW-1:0];
      rem_d = '0;
      dmag_d = dabs[DM-1:0];
      neg_d = num_i[NUM_W-1] ^ den_i[DEN_W-1];
    end else if (run_q) begin
      if (cnt_q == CW'(MW)) begin
        run_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          res_d = (rem_q != '0) ? -$signed({2'b00, quo_q}) - QUO_W'(1)
                                : -$signed({2'b00, quo_q});
        end else begin
          res_d = $signed({2'b00, quo_q});
        end
      end else begin
        cnt_d = cnt_q + CW'(1);
        if (!trial[DM+1]) begin
          rem_d = trial[DM-1:0];
          quo_d = {quo_q[MW-2:0], 1'b1};
        end else begin
          rem_d = rsh[DM-1:0];
          quo_d = {quo_q[MW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dmag_q <= dmag_d;
    neg_q <= neg_d;
    quo_o <= res_d;
  end

endmodule

[rtl/polar_wall_distance_map_unit.sv]
// Fill item: per map entry, ST_RAY, then ST_DIV and a wait on the divider for each of the
// four walls (a wall parallel to the ray skips the divider), then ST_STORE.
// Each wall intercept uses the shared 27-step divider.
// Query item: ST_QDIV for the window center, then ST_QADDR and ST_QCMP per map read; the result
// and the drop of busy come at the same edge, and the receiver cannot stall.
// After reset the map is cleared one entry a cycle (busy high).
module polar_wall_distance_map_unit #(
  parameter int ANGLE_STEPS = pwdm_pkg::ANGLE_STEPS_DEF,
  parameter int WINDOW_HALF = pwdm_pkg::WINDOW_HALF_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [pwdm_pkg::POS_W-1:0]      pos_x_i,
  input  logic [pwdm_pkg::POS_W-1:0]      pos_y_i,
  input  logic [pwdm_pkg::DEG_W-1:0]      heading_deg_i,
  output logic                            sensor_valid_o,
  output logic [pwdm_pkg::OUT_W-1:0]      sensor_distance_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [pwdm_pkg::POS_W-1:0]      cfg_data_i
);
  import pwdm_pkg::*;

  localparam int AW = $clog2(ANGLE_STEPS);
  localparam int DEG_INC = DEG_FULL / ANGLE_STEPS;
  localparam int REM_INC = DEG_FULL % ANGLE_STEPS;
  localparam int WIN_N = 2 * WINDOW_HALF + 1;
  localparam int WCW = $clog2(WIN_N + 1);
  localparam int CTR_SHIFT = 28;
  localparam int CTR_W = CTR_SHIFT + 11;
  localparam logic [CTR_W-1:0] CTR_MUL =
    CTR_W'(ANGLE_STEPS * ((2 ** CTR_SHIFT + DEG_FULL - 1) / DEG_FULL));

  state_e state_q, state_d;
  logic [POS_W-1:0] width_q, length_q;
  logic [POS_W-1:0] px_q, px_d, py_q, py_d;
  logic [DEG_W-1:0] head_q, head_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW:0] rem_q, rem_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic [1:0] k_q, k_d;
  logic signed [DEN_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [QUO_W-1:0] t_q, t_d;
  logic [WCW-1:0] wcnt_q, wcnt_d;
  logic [OUT_W-1:0] best_q, best_d;
  logic valid_d;
  logic [OUT_W-1:0] sdist_d;

  logic div_start;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic div_done;
  logic signed [QUO_W-1:0] div_quo;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [DIST_W-1:0] ram_wdata, ram_rdata;

  logic [POS_W-1:0] wall;
  logic [POS_W-1:0] pos;
  logic signed [DEN_W-1:0] comp;
  logic signed [POS_W:0] diff;
  logic signed [QUO_W-1:0] pick;
  logic [DEG_W:0] cos_arg;
  logic [DEG_W-1:0] cos_deg;
  logic [AW:0] rem_sum;
  logic [AW:0] start_idx;
  logic [AW:0] c_ext;
  logic [AW:0] idx_inc;
  logic [CTR_W-1:0] ctr_prod;

  pwdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  pwdm_ram #(
    .WIDTH(DIST_W),
    .DEPTH(ANGLE_STEPS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case (k_q)
      2'd0: begin
        wall = '0;
        pos = px_q;
        comp = dx_q;
      end
      2'd1: begin
        wall = '0;
        pos = py_q;
        comp = dy_q;
      end
      2'd2: begin
        wall = width_q;
        pos = px_q;
        comp = dx_q;
      end
      default: begin
        wall = length_q;
        pos = py_q;
        comp = dy_q;
      end
    endcase
  end

  assign diff = $signed({1'b0, wall}) - $signed({1'b0, pos});
  assign cos_arg = {1'b0, deg_q} + (DEG_W + 1)'(DEG_QUARTER);
  assign cos_deg = (cos_arg >= (DEG_W + 1)'(DEG_FULL)) ?
                   DEG_W'(cos_arg - (DEG_W + 1)'(DEG_FULL)) : DEG_W'(cos_arg);
  assign rem_sum = rem_q + (AW + 1)'(REM_INC);
  assign ctr_prod = CTR_W'(head_q) * CTR_MUL;
  assign c_ext = {1'b0, ctr_prod[CTR_SHIFT +: AW]} + (AW + 1)'(ANGLE_STEPS - WINDOW_HALF);
  assign start_idx = (c_ext >= (AW + 1)'(ANGLE_STEPS)) ?
                     c_ext - (AW + 1)'(ANGLE_STEPS) : c_ext;
  assign idx_inc = {1'b0, idx_q} + (AW + 1)'(1);

  always_comb begin
    state_d = state_q;
    px_d = px_q;
    py_d = py_q;
    head_d = head_q;
    idx_d = idx_q;
    rem_d = rem_q;
    deg_d = deg_q;
    k_d = k_q;
    dx_d = dx_q;
    dy_d = dy_q;
    t_d = t_q;
    wcnt_d = wcnt_q;
    best_d = best_q;
    valid_d = 1'b0;
    sdist_d = sensor_distance_o;
    div_start = 1'b0;
    div_num = $signed({diff, SHIFT_Q14'(0)});
    div_den = comp;
    ram_we = 1'b0;
    ram_addr = idx_q;
    ram_wdata = '0;
    pick = (comp == '0) ? -QUO_W'(1) : div_quo;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(ANGLE_STEPS - 1)) begin
          idx_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          px_d = pos_x_i;
          py_d = pos_y_i;
          head_d = (heading_deg_i >= DEG_W'(DEG_FULL)) ?
                   heading_deg_i - DEG_W'(DEG_FULL) : heading_deg_i;
          idx_d = '0;
          rem_d = '0;
          deg_d = '0;
          state_d = action_i ? ST_QDIV : ST_RAY;
        end
      end
      ST_RAY: begin
        dx_d = sin_q14(cos_deg);
        dy_d = sin_q14(deg_q);
        k_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (comp == '0) begin
          t_d = (k_q == 2'd0) ? pick : choose(t_q, pick);
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) state_d = ST_STORE;
        end else begin
          div_start = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          t_d = (k_q == 2'd0) ? pick : choose(t_q, pick);
          k_d = k_q + 2'd1;
          state_d = (k_q == 2'd3) ? ST_STORE : ST_DIV;
        end
      end
      ST_STORE: begin
        ram_we = 1'b1;
        if (t_q < 0) ram_wdata = '0;
        else if (t_q > QUO_W'(MAP_MAX)) ram_wdata = DIST_W'(MAP_MAX);
        else ram_wdata = t_q[DIST_W-1:0];
        idx_d = idx_q + AW'(1);
        if (rem_sum >= (AW + 1)'(ANGLE_STEPS)) begin
          rem_d = rem_sum - (AW + 1)'(ANGLE_STEPS);
          deg_d = deg_q + DEG_W'(DEG_INC + 1);
        end else begin
          rem_d = rem_sum;
          deg_d = deg_q + DEG_W'(DEG_INC);
        end
        state_d = (idx_q == AW'(ANGLE_STEPS - 1)) ? ST_IDLE : ST_RAY;
      end
      ST_QDIV: begin
        idx_d = start_idx[AW-1:0];
        wcnt_d = '0;
        best_d = OUT_W'(CAP_Q4);
        state_d = ST_QADDR;
      end
      ST_QADDR: begin
        state_d = ST_QCMP;
      end
      ST_QCMP: begin
        if (ram_rdata < DIST_W'(best_q)) best_d = ram_rdata[OUT_W-1:0];
        idx_d = (idx_inc >= (AW + 1)'(ANGLE_STEPS)) ? '0 : idx_inc[AW-1:0];
        wcnt_d = wcnt_q + WCW'(1);
        if (wcnt_q == WCW'(WIN_N - 1)) begin
          valid_d = 1'b1;
          sdist_d = (ram_rdata < DIST_W'(best_q)) ? ram_rdata[OUT_W-1:0] : best_q;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_QADDR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q <= '0;
      k_q <= '0;
      wcnt_q <= '0;
      sensor_valid_o <= 1'b0;
      width_q <= POS_W'(3840);
      length_q <= POS_W'(3840);
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      k_q <= k_d;
      wcnt_q <= wcnt_d;
      sensor_valid_o <= valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_WIDTH) width_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_LENGTH) length_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    head_q <= head_d;
    rem_q <= rem_d;
    deg_q <= deg_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    t_q <= t_d;
    best_q <= best_d;
    sensor_distance_o <= sdist_d;
  end

endmodule
